@@ design/urlpd_pkg.sv @@
// urlpd_pkg: shared types, character constants and helper functions
// for the URL percent decoder. No dependencies.
`default_nettype none
package urlpd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PCT     = 8'h25;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  localparam int GRP_SLOTS = 3;
  localparam int QDEPTH    = 2;

  // escape tracking: idle, percent held, percent and one char held
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HELD = 3'b100
  } phase_t;

  // bytes produced by one source character
  typedef struct packed {
    logic [GRP_SLOTS-1:0][7:0] bytes;
    logic [1:0]                cnt;
    logic                      last;
  } group_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'd0;
    ok = 1'b0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d  = c - CHAR_ZERO;
      ok = 1'b1;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d  = c - CHAR_UPPER_A + HEX_TEN;
      ok = 1'b1;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d  = c - CHAR_LOWER_A + HEX_TEN;
      ok = 1'b1;
    end
    return {ok, d[3:0]};
  endfunction

  // plain character outside an escape
  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

  // character that ends a string: a lone percent sign reads as '?'
  function automatic logic [7:0] term_map(input logic [7:0] c);
    return (c == CHAR_PCT) ? CHAR_QMARK : plain_map(c);
  endfunction

endpackage
`default_nettype wire

@@ design/urlpd_in_if.sv @@
// urlpd_in_if: valid/ready channel carrying encoded source characters.
// No dependencies.
`default_nettype none
interface urlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;
  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface
`default_nettype wire

@@ design/urlpd_out_if.sv @@
// urlpd_out_if: valid/ready channel carrying decoded bytes.
// No dependencies.
`default_nettype none
interface urlpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface
`default_nettype wire

@@ design/urlpd_front.sv @@
// urlpd_front: accepts characters, tracks escape state and builds the
// group of up to three decoded bytes per character. Uses urlpd_pkg.
`default_nettype none
module urlpd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  urlpd_in_if.sink             enc,
  input  wire logic            full,
  output logic                 push,
  output urlpd_pkg::group_t    grp
);

  urlpd_pkg::phase_t phase, phase_next;
  logic [7:0]        held, held_next;
  logic [4:0]        hx_hi, hx_lo;
  logic              accept;
  logic [7:0]        c;
  logic              last;

  assign c         = enc.in_char;
  assign last      = enc.in_last;
  assign enc.ready = !full;
  assign accept    = enc.valid && !full;
  assign hx_hi     = urlpd_pkg::hex_val(held);
  assign hx_lo     = urlpd_pkg::hex_val(c);

  always_comb begin
    grp        = '0;
    grp.last   = last;
    phase_next = urlpd_pkg::PH_IDLE;
    held_next  = held;
    unique case (phase)
      urlpd_pkg::PH_PCT: begin
        if (last) begin
          grp.bytes[0] = urlpd_pkg::CHAR_QMARK;
          grp.bytes[1] = urlpd_pkg::term_map(c);
          grp.cnt      = 2'd2;
        end else begin
          held_next  = c;
          phase_next = urlpd_pkg::PH_HELD;
        end
      end
      urlpd_pkg::PH_HELD: begin
        grp.bytes[0] = urlpd_pkg::CHAR_QMARK;
        if (hx_hi[4] && hx_lo[4]) begin
          grp.bytes[0] = {hx_hi[3:0], hx_lo[3:0]};
          grp.cnt      = 2'd1;
        end else if (held == urlpd_pkg::CHAR_PCT) begin
          // held percent opens a new escape
          if (last) begin
            grp.bytes[1] = urlpd_pkg::CHAR_QMARK;
            grp.bytes[2] = urlpd_pkg::term_map(c);
            grp.cnt      = 2'd3;
          end else begin
            grp.cnt    = 2'd1;
            held_next  = c;
            phase_next = urlpd_pkg::PH_HELD;
          end
        end else begin
          grp.bytes[1] = urlpd_pkg::plain_map(held);
          if (c == urlpd_pkg::CHAR_PCT && !last) begin
            grp.cnt    = 2'd2;
            phase_next = urlpd_pkg::PH_PCT;
          end else begin
            grp.bytes[2] = urlpd_pkg::term_map(c);
            grp.cnt      = 2'd3;
          end
        end
      end
      default: begin
        if (c == urlpd_pkg::CHAR_PCT && !last) begin
          phase_next = urlpd_pkg::PH_PCT;
        end else begin
          grp.bytes[0] = urlpd_pkg::term_map(c);
          grp.cnt      = 2'd1;
        end
      end
    endcase
  end

  assign push = accept && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= urlpd_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule
`default_nettype wire

@@ design/urlpd_queue.sv @@
// urlpd_queue: two-entry queue of byte groups between front and back.
// Uses urlpd_pkg.
`default_nettype none
module urlpd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire urlpd_pkg::group_t   wr_grp,
  output logic                     full,
  input  wire logic                pop,
  output urlpd_pkg::group_t        head,
  output logic                     empty
);

  localparam int PW = $clog2(urlpd_pkg::QDEPTH);
  localparam int CW = $clog2(urlpd_pkg::QDEPTH + 1);

  urlpd_pkg::group_t mem [urlpd_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     fill;

  assign full  = (fill == CW'(urlpd_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/urlpd_back.sv @@
// urlpd_back: sends the bytes of the head group one beat at a time and
// releases the group after its final byte. Uses urlpd_pkg.
`default_nettype none
module urlpd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire urlpd_pkg::group_t  head,
  input  wire logic               empty,
  output logic                    pop,
  urlpd_out_if.source             dec
);

  logic [1:0] idx;
  logic       final_byte;

  assign final_byte   = (idx == head.cnt - 2'd1);
  assign dec.valid    = !empty;
  assign dec.out_byte = head.bytes[idx];
  assign dec.out_last = head.last && final_byte;
  assign pop          = dec.valid && dec.ready && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (dec.valid && dec.ready) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ design/url_percent_decoder.sv @@
// url_percent_decoder: top level, front decoder, group queue, byte sender.
// Uses urlpd_pkg, urlpd_in_if, urlpd_out_if, urlpd_front, urlpd_queue, urlpd_back.
// Decodes a URL-encoded character stream ('+' to space, %XX to a byte, bad
// or cut-off escapes to '?') with one character accepted per cycle while
// each character yields at most one byte; a character that yields n bytes
// holds the output for n beats; the sender emits one byte per cycle when ready.
// A two-entry queue of byte groups sits between the two sides, so input
// stalls only when that queue is full. The bytes of a character are
// queued before they reach the output; out_last marks a string's end.
`default_nettype none
module url_percent_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  urlpd_in_if.sink    enc,
  urlpd_out_if.source dec
);

  urlpd_pkg::group_t grp, head;
  logic              push, full, pop, empty;

  urlpd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .enc  (enc),
    .full (full),
    .push (push),
    .grp  (grp)
  );

  urlpd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_grp (grp),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  urlpd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .dec   (dec)
  );

endmodule
`default_nettype wire

@@ design/urlpd_checker.sv @@
// urlpd_checker: port-level assertions for url_percent_decoder, bound in
// below. No package dependencies.
`default_nettype none
module urlpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       enc_valid,
  input wire logic       enc_ready,
  input wire logic       enc_last,
  input wire logic       dec_valid,
  input wire logic       dec_ready,
  input wire logic [7:0] dec_byte,
  input wire logic       dec_last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !dec_valid && enc_ready)
    else $error("queue not empty after reset");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_ready && enc_last |=> dec_valid)
    else $error("string end gave no byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_byte) && $stable(dec_last))
    else $error("stalled beat changed");

  a_ready_after_drain: assert property (@(posedge clk) disable iff (rst)
    !dec_valid |-> enc_ready)
    else $error("input stalled with empty output");

endmodule

bind url_percent_decoder urlpd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .enc_valid (enc.valid),
  .enc_ready (enc.ready),
  .enc_last  (enc.in_last),
  .dec_valid (dec.valid),
  .dec_ready (dec.ready),
  .dec_byte  (dec.out_byte),
  .dec_last  (dec.out_last)
);
`default_nettype wire
